[rtl/core/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants for the k-way merge min-heap
// Sizes, heap entry and job formats, command and status codes, and the
// entry ordering function used by the sift engine.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

   // Heap capacity equals the number of merged streams.
   localparam int NUM_LANES       = 8;
   localparam int VALUE_WIDTH     = 32;

   // Port field widths are fixed by the interface.
   localparam int LANE_WIDTH      = 3;
   localparam int OUT_VALUE_WIDTH = 32;
   localparam int OCC_WIDTH       = 4;

   localparam int ADDR_WIDTH      = $clog2(NUM_LANES);
   localparam int COUNT_WIDTH     = $clog2(NUM_LANES + 1);
   localparam int CHILD_WIDTH     = ADDR_WIDTH + 2;

   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_POP,
      OP_FULL,
      OP_EMPTY
   } op_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED,
      STATUS_POPPED,
      STATUS_EMPTY,
      STATUS_FULL
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_STEP,
      ST_INS_CMP,
      ST_POP_READ,
      ST_POP_LOAD,
      ST_DOWN_STEP,
      ST_DOWN_CMP,
      ST_RESP
   } back_state_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [LANE_WIDTH-1:0]         lane;
   } entry_type;

   // One classified transaction on its way to the heap engine. The count is
   // the heap occupancy before this transaction.
   typedef struct packed {
      op_type                 op;
      logic [COUNT_WIDTH-1:0] count;
      entry_type              entry;
   } job_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   // Smaller value first; equal values leave in lane order.
   function automatic logic entry_before(input entry_type a, input entry_type b);
      logic result;
      if (a.value != b.value) begin
         result = ($signed(a.value) < $signed(b.value));
      end else begin
         result = (a.lane < b.lane);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[rtl/core/kwm_front.sv]
// ----------------------------------------------------------------------------
// kwm_front: request intake and classification
// Accepts request transactions, tracks heap occupancy and tags each one as
// a real insert or pop, or as a rejected full insert or empty pop.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire                                  req_command,
   input  wire  [kwm_pkg::LANE_WIDTH-1:0]       req_lane,
   input  wire  signed [kwm_pkg::OUT_VALUE_WIDTH-1:0] req_value,
   input  kwm_pkg::queue_status_type            q_status,
   output logic                                 q_push,
   output kwm_pkg::job_type                     q_push_job,
   output logic [kwm_pkg::COUNT_WIDTH-1:0]      count
);

   logic [kwm_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [kwm_pkg::COUNT_WIDTH-1:0] count_in;

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;
   assign count     = count_ff;

   always_comb begin
      q_push_job.count       = count_ff;
      q_push_job.entry.lane  = req_lane;
      // The value is read as a VALUE_WIDTH-bit number from the port's low bits.
      q_push_job.entry.value = kwm_pkg::VALUE_WIDTH'($unsigned(req_value));
      count_in               = count_ff;
      if (req_command == kwm_pkg::CMD_INSERT) begin
         if (count_ff == kwm_pkg::COUNT_WIDTH'(kwm_pkg::NUM_LANES)) begin
            q_push_job.op = kwm_pkg::OP_FULL;
         end else begin
            q_push_job.op = kwm_pkg::OP_INSERT;
            count_in      = count_ff + kwm_pkg::COUNT_WIDTH'(1);
         end
      end else begin
         if (count_ff == '0) begin
            q_push_job.op = kwm_pkg::OP_EMPTY;
         end else begin
            q_push_job.op = kwm_pkg::OP_POP;
            count_in      = count_ff - kwm_pkg::COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (q_push) begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/kwm_queue.sv]
// ----------------------------------------------------------------------------
// kwm_queue: job queue between intake and heap engine
// A short first-in first-out buffer of classified jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       q_push,
   input  kwm_pkg::job_type          q_push_job,
   input  wire                       q_pop,
   output kwm_pkg::queue_status_type q_status,
   output kwm_pkg::job_type          q_head
);

   kwm_pkg::job_type                 job_ff [kwm_pkg::QUEUE_DEPTH];
   logic [kwm_pkg::QPTR_WIDTH-1:0]   wr_ptr_ff;
   logic [kwm_pkg::QPTR_WIDTH-1:0]   wr_ptr_in;
   logic [kwm_pkg::QPTR_WIDTH-1:0]   rd_ptr_ff;
   logic [kwm_pkg::QPTR_WIDTH-1:0]   rd_ptr_in;
   logic [kwm_pkg::QCOUNT_WIDTH-1:0] fill_ff;
   logic [kwm_pkg::QCOUNT_WIDTH-1:0] fill_in;

   function automatic logic [kwm_pkg::QPTR_WIDTH-1:0] ptr_next(
      input logic [kwm_pkg::QPTR_WIDTH-1:0] ptr
   );
      logic [kwm_pkg::QPTR_WIDTH-1:0] result;
      if (ptr == kwm_pkg::QPTR_WIDTH'(kwm_pkg::QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + kwm_pkg::QPTR_WIDTH'(1);
      end
      return result;
   endfunction

   assign q_status.valid = (fill_ff != '0);
   assign q_status.full  = (fill_ff == kwm_pkg::QCOUNT_WIDTH'(kwm_pkg::QUEUE_DEPTH));
   assign q_head         = job_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = q_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = q_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case ({q_push, q_pop})
         2'b10:   fill_in = fill_ff + kwm_pkg::QCOUNT_WIDTH'(1);
         2'b01:   fill_in = fill_ff - kwm_pkg::QCOUNT_WIDTH'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         job_ff[wr_ptr_ff] <= q_push_job;
      end
   end

endmodule

`default_nettype wire

[rtl/core/kwm_back.sv]
// ----------------------------------------------------------------------------
// kwm_back: heap engine
// Runs one job at a time against the heap memory: hole-based sift-up for an
// insert, root removal and sift-down for a pop, then registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_back (
   input  wire                                         clock,
   input  wire                                         reset,
   input  kwm_pkg::queue_status_type                   q_status,
   input  kwm_pkg::job_type                            q_head,
   output logic                                        q_pop,
   output logic                                        rsp_valid,
   input  wire                                         rsp_stall,
   output logic [1:0]                                  rsp_status,
   output logic signed [kwm_pkg::OUT_VALUE_WIDTH-1:0]  rsp_min_value,
   output logic [kwm_pkg::LANE_WIDTH-1:0]              rsp_min_lane,
   output logic [kwm_pkg::OCC_WIDTH-1:0]               rsp_occupancy
);

   kwm_pkg::back_state_type state_ff;
   kwm_pkg::back_state_type state_in;

   // Heap memory: one write port, two registered read ports.
   kwm_pkg::entry_type heap_mem_ff [kwm_pkg::NUM_LANES];
   kwm_pkg::entry_type rd_a_ff;
   kwm_pkg::entry_type rd_b_ff;
   logic                            mem_we;
   logic [kwm_pkg::ADDR_WIDTH-1:0]  mem_waddr;
   kwm_pkg::entry_type              mem_wdata;
   logic [kwm_pkg::ADDR_WIDTH-1:0]  rd_a_addr;
   logic [kwm_pkg::ADDR_WIDTH-1:0]  rd_b_addr;

   // Sift working registers.
   kwm_pkg::entry_type              cur_ff;
   kwm_pkg::entry_type              cur_in;
   logic [kwm_pkg::ADDR_WIDTH-1:0]  pos_ff;
   logic [kwm_pkg::ADDR_WIDTH-1:0]  pos_in;
   logic [kwm_pkg::COUNT_WIDTH-1:0] cnt_ff;
   logic [kwm_pkg::COUNT_WIDTH-1:0] cnt_in;

   // Pending response.
   kwm_pkg::status_type             res_status_ff;
   kwm_pkg::status_type             res_status_in;
   logic [kwm_pkg::VALUE_WIDTH-1:0] res_value_ff;
   logic [kwm_pkg::VALUE_WIDTH-1:0] res_value_in;
   logic [kwm_pkg::LANE_WIDTH-1:0]  res_lane_ff;
   logic [kwm_pkg::LANE_WIDTH-1:0]  res_lane_in;
   logic [kwm_pkg::COUNT_WIDTH-1:0] res_count_ff;
   logic [kwm_pkg::COUNT_WIDTH-1:0] res_count_in;

   // Output register.
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   kwm_pkg::status_type                  rsp_status_ff;
   kwm_pkg::status_type                  rsp_status_in;
   logic [kwm_pkg::OUT_VALUE_WIDTH-1:0]  rsp_value_ff;
   logic [kwm_pkg::OUT_VALUE_WIDTH-1:0]  rsp_value_in;
   logic [kwm_pkg::LANE_WIDTH-1:0]       rsp_lane_ff;
   logic [kwm_pkg::LANE_WIDTH-1:0]       rsp_lane_in;
   logic [kwm_pkg::OCC_WIDTH-1:0]        rsp_occ_ff;
   logic [kwm_pkg::OCC_WIDTH-1:0]        rsp_occ_in;

   // Shared datapath terms.
   logic                             out_free;
   logic [kwm_pkg::ADDR_WIDTH-1:0]   parent;
   logic [kwm_pkg::CHILD_WIDTH-1:0]  left;
   logic [kwm_pkg::CHILD_WIDTH-1:0]  right;
   logic [kwm_pkg::CHILD_WIDTH-1:0]  cnt_ext;
   logic                             left_ok;
   logic                             right_ok;
   logic                             cur_lt_a;
   logic                             a_lt_cur;
   logic                             b_lt_cur;
   logic                             b_lt_a;
   logic                             pick_a;
   logic                             pick_b;
   logic [kwm_pkg::ADDR_WIDTH-1:0]   child_idx;
   kwm_pkg::entry_type               child_entry;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign parent    = (pos_ff - kwm_pkg::ADDR_WIDTH'(1)) >> 1;
   assign left      = {1'b0, pos_ff, 1'b1};
   assign right     = left + kwm_pkg::CHILD_WIDTH'(1);
   assign cnt_ext   = kwm_pkg::CHILD_WIDTH'(cnt_ff);
   assign left_ok   = (left < cnt_ext);
   assign right_ok  = (right < cnt_ext);
   assign cur_lt_a  = kwm_pkg::entry_before(cur_ff, rd_a_ff);
   assign a_lt_cur  = kwm_pkg::entry_before(rd_a_ff, cur_ff);
   assign b_lt_cur  = kwm_pkg::entry_before(rd_b_ff, cur_ff);
   assign b_lt_a    = kwm_pkg::entry_before(rd_b_ff, rd_a_ff);
   // The right child is taken when it exists and is smaller than whichever of
   // the current entry and the left child is smaller.
   assign pick_b      = right_ok && (a_lt_cur ? b_lt_a : b_lt_cur);
   assign pick_a      = a_lt_cur && !pick_b;
   assign child_idx   = pick_b ? right[kwm_pkg::ADDR_WIDTH-1:0]
                               : left[kwm_pkg::ADDR_WIDTH-1:0];
   assign child_entry = pick_b ? rd_b_ff : rd_a_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kwm_pkg::ST_IDLE: begin
            if (q_status.valid) begin
               case (q_head.op)
                  kwm_pkg::OP_INSERT: state_in = kwm_pkg::ST_INS_STEP;
                  kwm_pkg::OP_POP:    state_in = kwm_pkg::ST_POP_READ;
                  default:            state_in = kwm_pkg::ST_RESP;
               endcase
            end
         end
         kwm_pkg::ST_INS_STEP: begin
            state_in = (pos_ff == '0) ? kwm_pkg::ST_RESP : kwm_pkg::ST_INS_CMP;
         end
         kwm_pkg::ST_INS_CMP: begin
            state_in = cur_lt_a ? kwm_pkg::ST_INS_STEP : kwm_pkg::ST_RESP;
         end
         kwm_pkg::ST_POP_READ: begin
            state_in = kwm_pkg::ST_POP_LOAD;
         end
         kwm_pkg::ST_POP_LOAD: begin
            state_in = (cnt_ff == kwm_pkg::COUNT_WIDTH'(1)) ? kwm_pkg::ST_RESP
                                                            : kwm_pkg::ST_DOWN_STEP;
         end
         kwm_pkg::ST_DOWN_STEP: begin
            state_in = left_ok ? kwm_pkg::ST_DOWN_CMP : kwm_pkg::ST_RESP;
         end
         kwm_pkg::ST_DOWN_CMP: begin
            state_in = (pick_a || pick_b) ? kwm_pkg::ST_DOWN_STEP : kwm_pkg::ST_RESP;
         end
         kwm_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = kwm_pkg::ST_IDLE;
            end
         end
         default: state_in = kwm_pkg::ST_IDLE;
      endcase
   end

   // Datapath control and register next values.
   always_comb begin
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = cur_ff;
      rd_a_addr     = '0;
      rd_b_addr     = '0;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_lane_in   = res_lane_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_lane_in   = rsp_lane_ff;
      rsp_occ_in    = rsp_occ_ff;
      case (state_ff)
         kwm_pkg::ST_IDLE: begin
            if (q_status.valid) begin
               q_pop        = 1'b1;
               cur_in       = q_head.entry;
               cnt_in       = q_head.count;
               pos_in       = kwm_pkg::ADDR_WIDTH'(q_head.count);
               res_value_in = '0;
               res_lane_in  = '0;
               res_count_in = q_head.count;
               case (q_head.op)
                  kwm_pkg::OP_INSERT: begin
                     res_status_in = kwm_pkg::STATUS_INSERTED;
                     res_count_in  = q_head.count + kwm_pkg::COUNT_WIDTH'(1);
                  end
                  kwm_pkg::OP_POP: begin
                     res_status_in = kwm_pkg::STATUS_POPPED;
                     res_count_in  = q_head.count - kwm_pkg::COUNT_WIDTH'(1);
                  end
                  kwm_pkg::OP_FULL: begin
                     res_status_in = kwm_pkg::STATUS_FULL;
                  end
                  default: begin
                     res_status_in = kwm_pkg::STATUS_EMPTY;
                  end
               endcase
            end
         end
         kwm_pkg::ST_INS_STEP: begin
            if (pos_ff == '0) begin
               mem_we = 1'b1;
            end else begin
               rd_a_addr = parent;
            end
         end
         kwm_pkg::ST_INS_CMP: begin
            mem_we = 1'b1;
            if (cur_lt_a) begin
               // Move the parent down into the hole and climb one level.
               mem_wdata = rd_a_ff;
               pos_in    = parent;
            end
         end
         kwm_pkg::ST_POP_READ: begin
            rd_a_addr = '0;
            rd_b_addr = kwm_pkg::ADDR_WIDTH'(cnt_ff - kwm_pkg::COUNT_WIDTH'(1));
         end
         kwm_pkg::ST_POP_LOAD: begin
            res_value_in = rd_a_ff.value;
            res_lane_in  = rd_a_ff.lane;
            cur_in       = rd_b_ff;
            cnt_in       = cnt_ff - kwm_pkg::COUNT_WIDTH'(1);
            pos_in       = '0;
         end
         kwm_pkg::ST_DOWN_STEP: begin
            if (left_ok) begin
               rd_a_addr = left[kwm_pkg::ADDR_WIDTH-1:0];
               rd_b_addr = right[kwm_pkg::ADDR_WIDTH-1:0];
            end else begin
               mem_we = 1'b1;
            end
         end
         kwm_pkg::ST_DOWN_CMP: begin
            mem_we = 1'b1;
            if (pick_a || pick_b) begin
               // Move the smaller child up into the hole and descend.
               mem_wdata = child_entry;
               pos_in    = child_idx;
            end
         end
         kwm_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = kwm_pkg::OUT_VALUE_WIDTH'(res_value_ff);
               rsp_lane_in   = res_lane_ff;
               rsp_occ_in    = kwm_pkg::OCC_WIDTH'(res_count_ff);
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kwm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_lane_ff   <= res_lane_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_lane_ff   <= rsp_lane_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= heap_mem_ff[rd_a_addr];
      rd_b_ff <= heap_mem_ff[rd_b_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_min_value = rsp_value_ff;
   assign rsp_min_lane  = rsp_lane_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

`default_nettype wire

[rtl/core/k_way_merge_min_heap.sv]
// ----------------------------------------------------------------------------
// k_way_merge_min_heap: min-heap merge of sorted input streams
// A feeder inserts lane-tagged values and pops the smallest; each request
// transaction yields exactly one response transaction.
// ----------------------------------------------------------------------------
// Usage. The request channel (req_valid, req_stall, req_command, req_lane,
// req_value) carries an insert (command 0) of a value from a lane, or a pop
// (command 1). The response channel (rsp_valid, rsp_stall, ...) returns one
// transaction per request, in request order: the status (inserted, popped,
// empty on pop, full with the insert dropped), the popped value and lane
// (zero otherwise) and the number of entries held afterward. Equal values
// leave in ascending lane order. After a pop the feeder draws the next
// element from the returned lane.
// Timing. Requests are classified on entry and wait in a two-deep job queue,
// so intake continues while the heap engine works. The engine handles one
// job at a time through a memory with two registered read ports. A rejected
// request goes straight to the response register. An insert climbs from the
// new leaf position one level per compare step until its value no longer
// precedes its parent or reaches the root. A pop reads the root and the last
// entry, loads the last entry as the new root and, unless the heap is now
// empty, sinks it one level per compare step. A new job starts only once the
// engine has registered the previous response.
// Reset empties the heap, the queue and the response register; heap memory
// contents are not cleared and are never read before being written. While
// rsp_stall is high the response holds, the engine waits with its next
// result, and req_stall rises once the job queue has filled.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_merge_min_heap (
   input  wire                                        clock,
   input  wire                                        reset,
   // Request channel.
   input  wire                                        req_valid,
   output logic                                       req_stall,
   input  wire                                        req_command,
   input  wire  [kwm_pkg::LANE_WIDTH-1:0]             req_lane,
   input  wire  signed [kwm_pkg::OUT_VALUE_WIDTH-1:0] req_value,
   // Response channel.
   output logic                                       rsp_valid,
   input  wire                                        rsp_stall,
   output logic [1:0]                                 rsp_status,
   output logic signed [kwm_pkg::OUT_VALUE_WIDTH-1:0] rsp_min_value,
   output logic [kwm_pkg::LANE_WIDTH-1:0]             rsp_min_lane,
   output logic [kwm_pkg::OCC_WIDTH-1:0]              rsp_occupancy
);

   kwm_pkg::queue_status_type        q_status;
   kwm_pkg::job_type                 q_push_job;
   kwm_pkg::job_type                 q_head;
   logic                             q_push;
   logic                             q_pop;
   logic [kwm_pkg::COUNT_WIDTH-1:0]  fe_count;

   // The front tracks occupancy itself, so every job reaches the engine
   // already resolved into a real insert, a real pop or a rejection.
   kwm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_lane    (req_lane),
      .req_value   (req_value),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_push_job  (q_push_job),
      .count       (fe_count)
   );

   kwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .q_push     (q_push),
      .q_push_job (q_push_job),
      .q_pop      (q_pop),
      .q_status   (q_status),
      .q_head     (q_head)
   );

   // The engine owns the heap memory and the response register.
   kwm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_min_value (rsp_min_value),
      .rsp_min_lane  (rsp_min_lane),
      .rsp_occupancy (rsp_occupancy)
   );

   // The tracked occupancy never exceeds the heap capacity.
   assert property (@(posedge clock) disable iff (reset)
      fe_count <= kwm_pkg::COUNT_WIDTH'(kwm_pkg::NUM_LANES))
      else $error("occupancy beyond heap capacity");

   // The front never pushes a job into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("job pushed into full queue");

   // An empty pop reports no value and an empty heap.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == kwm_pkg::STATUS_EMPTY) |->
         (rsp_min_value == '0 && rsp_min_lane == '0 && rsp_occupancy == '0))
      else $error("empty pop response malformed");

   // A dropped insert reports a full heap.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == kwm_pkg::STATUS_FULL) |->
         (rsp_min_value == '0 &&
          rsp_occupancy == kwm_pkg::OCC_WIDTH'(kwm_pkg::NUM_LANES)))
      else $error("full insert response malformed");

endmodule

`default_nettype wire
